/* hdl/cpg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpg_pkg
// Shared constants and types for the contact process step engine.
// ----------------------------------------------------------------------------
package cpg_pkg;

    localparam int SITES       = 1024;
    localparam int IDX_W       = $clog2(SITES);
    localparam int SITE_W      = 10;
    localparam int CNT_W       = 11;
    localparam int LAMBDA_W    = 16;
    localparam int FRAC_W      = 17;
    localparam int W_W         = 27;
    localparam int RATE_W      = LAMBDA_W + 2;
    localparam int TGT_W       = W_W + FRAC_W;
    localparam logic [LAMBDA_W-1:0] LAMBDA_RESET = 16'd9384;
    localparam logic [RATE_W-1:0]   ACTIVE_RATE  = 18'd8192;

    typedef enum logic [1:0] {
        CMD_STEP = 2'd0,
        CMD_SET  = 2'd1,
        CMD_CLR  = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOADW,
        S_TARGET,
        S_SCAN,
        S_FIN
    } t_state;

endpackage

/* hdl/cpg_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpg_cell
// One lattice site of the rotating site ring.
// ----------------------------------------------------------------------------
module cpg_cell (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_shift,
    input  logic i_d,
    output logic o_q
);

    logic r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else if (i_shift) begin
            r_bit <= i_d;
        end
    end

    assign o_q = r_bit;

endmodule

/* hdl/contact_process_gillespie_step_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contact_process_gillespie_step_top
// One dimensional contact process, one event per command word.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Commands are
// a stochastic step and forcing one site active or inactive.
// The sites sit in a cell ring, rotating one place per scan cycle; the
// head cell is examined with its two neighbours, and a running rate sum is
// compared with the scaled random target. Every command rotates the ring
// once so the sites return to their home cells.
// After acceptance the engine runs the load, target, scan and finish
// states, and strobe is registered from the finish state; a new word is
// taken only once the engine is back in idle.
// Strobe is high for a single cycle with the result on the o_ ports; the
// receiver cannot stall, so it must take it then.
// lambda is written through i_cfg_we / i_cfg_wdata while busy is low;
// the user must keep to this; the block itself does not enforce it.
// Synchronous reset clears all sites, both counts, and sets lambda to 9384.
// ----------------------------------------------------------------------------
module contact_process_gillespie_step_top
    import cpg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_cmd,
    input  logic [SITE_W-1:0]   i_site_index,
    input  logic [FRAC_W-1:0]   i_rand_frac,
    input  logic                i_cfg_we,
    input  logic [LAMBDA_W-1:0] i_cfg_wdata,
    output logic                strobe,
    output logic                o_event_done,
    output logic [SITE_W-1:0]   o_chosen_site,
    output logic                o_new_state,
    output logic [W_W-1:0]      o_total_rate,
    output logic [CNT_W-1:0]    o_active_sites
);

    t_state r_state, n_state;

    logic [LAMBDA_W-1:0] r_lambda;
    logic [CNT_W-1:0]    r_active;
    logic [CNT_W-1:0]    r_unlike;
    logic [1:0]          r_cmd;
    logic [SITE_W-1:0]   r_idx;
    logic [FRAC_W-1:0]   r_frac;
    logic [W_W-1:0]      r_w;
    logic [TGT_W-1:0]    r_target;
    logic [W_W-1:0]      r_sum;
    logic [IDX_W-1:0]    r_cnt;
    logic                r_done;
    logic [IDX_W-1:0]    r_chosen;
    logic                r_newst;

    logic [SITES-1:0]    w_q;
    logic                w_shift;
    logic                w_head, w_left, w_right, w_has_l, w_has_r;
    logic [RATE_W-1:0]   w_rate;
    logic [W_W-1:0]      w_nsum;
    logic                w_hit;
    logic                w_want;
    logic [W_W-1:0]      w_total;
    logic                w_last;

    // site ring: cell k takes from cell k+1, head re-enters at the tail
    for (genvar k = 0; k < SITES; k++) begin : g_cell
        logic w_d;
        if (k == SITES - 1) begin : g_tail
            assign w_d = w_head ^ w_hit;
        end else begin : g_mid
            assign w_d = w_q[k+1];
        end
        cpg_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_d     (w_d),
            .o_q     (w_q[k])
        );
    end

    assign w_shift = (r_state == S_SCAN);
    assign w_last  = (r_cnt == IDX_W'(SITES - 1));
    assign w_head  = w_q[0];
    assign w_has_l = (r_cnt != '0);
    assign w_has_r = !w_last;
    assign w_left  = w_has_l & w_q[SITES-1];
    assign w_right = w_has_r & w_q[1];

    always_comb begin
        if (w_head) begin
            w_rate = ACTIVE_RATE;
        end else begin
            w_rate = (w_left ? RATE_W'(r_lambda) : '0) + (w_right ? RATE_W'(r_lambda) : '0);
        end
    end

    assign w_nsum = r_sum + W_W'(w_rate);
    assign w_want = (r_cmd == CMD_SET);
    assign w_total = W_W'({r_active, 13'b0}) + W_W'(r_unlike) * W_W'(r_lambda);

    always_comb begin
        w_hit = 1'b0;
        if (w_shift && !r_done) begin
            case (r_cmd)
                CMD_STEP: w_hit = (w_rate != '0) && ({w_nsum, 16'b0} >= {1'b0, r_target});
                CMD_SET, CMD_CLR: w_hit = (32'(r_cnt) == 32'(r_idx)) && (w_head != w_want);
                default: w_hit = 1'b0;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (start) n_state = S_LOADW;
            S_LOADW:  n_state = S_TARGET;
            S_TARGET: n_state = S_SCAN;
            S_SCAN:   if (w_last) n_state = S_FIN;
            S_FIN:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        busy = (r_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_lambda <= LAMBDA_RESET;
            r_active <= '0;
            r_unlike <= '0;
            r_done   <= 1'b0;
            strobe   <= 1'b0;
        end else begin
            r_state <= n_state;
            strobe  <= (r_state == S_FIN);
            if (i_cfg_we) begin
                r_lambda <= i_cfg_wdata;
            end
            if (r_state == S_IDLE && start) begin
                r_done <= 1'b0;
            end
            if (w_hit) begin
                r_done <= 1'b0 | 1'b1;
                if (w_head) begin
                    r_active <= r_active - 1'b1;
                end else begin
                    r_active <= r_active + 1'b1;
                end
                r_unlike <= r_unlike
                    + CNT_W'(w_has_l && (w_q[SITES-1] == w_head))
                    + CNT_W'(w_has_r && (w_q[1] == w_head))
                    - CNT_W'(w_has_l && (w_q[SITES-1] != w_head))
                    - CNT_W'(w_has_r && (w_q[1] != w_head));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cmd  <= i_cmd;
                r_idx  <= i_site_index;
                r_frac <= i_rand_frac;
            end
            S_LOADW: begin
                r_w   <= w_total;
                r_sum <= '0;
                r_cnt <= '0;
            end
            S_TARGET: begin
                r_target <= r_w * r_frac;
            end
            S_SCAN: begin
                r_cnt <= r_cnt + 1'b1;
                if (!r_done && w_rate != '0) begin
                    r_sum <= w_nsum;
                end
                if (w_hit) begin
                    r_chosen <= r_cnt;
                    r_newst  <= ~w_head;
                end
            end
            S_FIN: begin
                o_event_done   <= r_done;
                o_chosen_site  <= r_done ? SITE_W'(r_chosen) : '0;
                o_new_state    <= r_done & r_newst;
                o_total_rate   <= w_total;
                o_active_sites <= r_active;
            end
            default: ;
        endcase
    end

    a_strobe_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        strobe |-> $past(r_state == S_FIN))
        else $error("result strobe without finished scan");

    a_no_event_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (strobe && !o_event_done) |-> (o_chosen_site == '0 && !o_new_state))
        else $error("idle result carries a site");

    a_single_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_hit) |=> !w_hit)
        else $error("two flips in one scan");

    a_counts_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_active) <= SITES) && (32'(r_unlike) < SITES))
        else $error("site counts out of range");

endmodule
